// ===== rtl/cnbc_pkg.sv =====
package cnbc_pkg;

    localparam int NUM_BOXES = 6;
    localparam int NUM_CHANNELS = 3;
    localparam int QUO_BITS = 8;
    localparam int NUM_CELLS = QUO_BITS;
    localparam int RAW_BITS = 16;
    localparam int DIVIDEND_BITS = RAW_BITS + QUO_BITS;
    localparam int BOX_BITS = 48;
    localparam int INDEX_BITS = 3;

    localparam logic [BOX_BITS-1:0] BOX_RESET = 48'hFFFF_FF00_0000;
    localparam logic [QUO_BITS-1:0] NORM_MAX = 8'hFF;

    // class codes on the result
    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_RED    = 3'd1,
        CLS_GREEN  = 3'd2,
        CLS_BLUE   = 3'd3,
        CLS_ORANGE = 3'd4,
        CLS_BROWN  = 3'd5,
        CLS_YELLOW = 3'd6
    } class_t;

    // register indexes on the configuration port
    typedef enum logic [INDEX_BITS-1:0] {
        REG_BOX_RED    = 3'd0,
        REG_BOX_GREEN  = 3'd1,
        REG_BOX_BLUE   = 3'd2,
        REG_BOX_ORANGE = 3'd3,
        REG_BOX_BROWN  = 3'd4,
        REG_BOX_YELLOW = 3'd5
    } reg_index_t;

    // box priority order, index -> class code
    localparam class_t BOX_CLASS [NUM_BOXES] = '{
        CLS_RED, CLS_GREEN, CLS_BLUE, CLS_ORANGE, CLS_BROWN, CLS_YELLOW
    };

    typedef struct packed {
        logic [RAW_BITS-1:0] raw_red;
        logic [RAW_BITS-1:0] raw_green;
        logic [RAW_BITS-1:0] raw_blue;
        logic [RAW_BITS-1:0] raw_clear;
    } sample_t;

    typedef struct packed {
        logic [2:0]          color_class;
        logic [QUO_BITS-1:0] norm_red;
        logic [QUO_BITS-1:0] norm_green;
        logic [QUO_BITS-1:0] norm_blue;
        logic                over_range;
    } result_t;

    typedef logic [BOX_BITS-1:0] box_t;
    typedef box_t [NUM_BOXES-1:0] box_array_t;

    // data handed from cell to cell; quo holds the unused low dividend
    // bits on top and the quotient bits shifted in from the bottom
    typedef struct packed {
        logic [RAW_BITS-1:0]                         divisor;
        logic [NUM_CHANNELS-1:0][RAW_BITS-1:0]       rem;
        logic [NUM_CHANNELS-1:0][QUO_BITS-1:0]       quo;
        logic [NUM_CHANNELS-1:0]                     over;
        logic                                        zero;
    } cell_data_t;

endpackage

// ===== rtl/color_normalize_box_classify.sv =====
// Color sample normalizer and box classifier.
//
// sample channel (sample_valid / sample_stall / sample): one raw red, green,
// blue and clear count per transfer. result channel (result_valid /
// result_stall / result): one class code, three normalized bytes and an
// over_range flag per sample, in sample order.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes one of
// the six class boxes; cfg_ready is always high, indexes 6 and 7 are dropped.
//
// Each channel is divided as 255*ch / clear by a row of eight identical
// restoring cells, one quotient bit per cell. From a sample transfer to
// result_valid an item passes the register for the 255x multiply and range
// check, then eight divider cells, then the register for the box compare.
// Throughput is one sample per cycle while the result is not stalled.
//
// Reset empties the pipeline and loads every box with min 255 / max 0, so
// no box matches until written. When the receiver stalls, items close up
// into empty stages; sample_stall rises only once every stage holds an item
// and the result is stalled.
module color_normalize_box_classify (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  cnbc_pkg::sample_t             sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output cnbc_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cnbc_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [cnbc_pkg::BOX_BITS-1:0] cfg_data
);
    import cnbc_pkg::*;

    box_array_t boxes_reg;
    logic       front_ready;
    logic       class_ready;
    logic       [NUM_CELLS:0] chain_valid;
    logic       [NUM_CELLS:0] chain_ready;
    cell_data_t chain_data [NUM_CELLS+1];

    // box registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOXES; i++)
                boxes_reg[i] <= BOX_RESET;
        end
        else if (cfg_valid && cfg_ready && cfg_index <= REG_BOX_YELLOW)
        begin
            boxes_reg[cfg_index] <= cfg_data;
        end
    end

    // multiply and range check
    cnbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample_valid),
        .up_data  (sample),
        .up_ready (front_ready),
        .dn_valid (chain_valid[0]),
        .dn_data  (chain_data[0]),
        .dn_ready (chain_ready[0])
    );

    assign sample_stall = !front_ready;

    // divider row
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cnbc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_data  (chain_data[k]),
            .up_ready (chain_ready[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_data  (chain_data[k+1]),
            .dn_ready (chain_ready[k+1])
        );
    end

    // box compare and output register
    cnbc_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .boxes    (boxes_reg),
        .up_valid (chain_valid[NUM_CELLS]),
        .up_data  (chain_data[NUM_CELLS]),
        .up_ready (class_ready),
        .dn_valid (result_valid),
        .dn_data  (result),
        .dn_ready (!result_stall)
    );

    assign chain_ready[NUM_CELLS] = class_ready;

    // input backpressure only with a blocked output
    a_stall_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample stalled while output not blocked");

    // a saturated channel matches no box
    a_over_no_class: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.over_range) |-> (result.color_class == CLS_NONE))
        else $error("class given for over-range sample");

    // over_range comes with a saturated byte
    a_over_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.over_range) |->
        (result.norm_red == NORM_MAX || result.norm_green == NORM_MAX
         || result.norm_blue == NORM_MAX))
        else $error("over_range without a saturated channel");

endmodule

// ===== rtl/cnbc_front.sv =====
module cnbc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  cnbc_pkg::sample_t  up_data,
    output logic               up_ready,
    output logic               dn_valid,
    output cnbc_pkg::cell_data_t dn_data,
    input  logic               dn_ready
);
    import cnbc_pkg::*;

    logic        valid_reg;
    cell_data_t  data_reg;
    cell_data_t  data_next;
    logic [NUM_CHANNELS-1:0][RAW_BITS-1:0] raw;
    logic [NUM_CHANNELS-1:0][DIVIDEND_BITS-1:0] dividend;

    assign raw[0] = up_data.raw_red;
    assign raw[1] = up_data.raw_green;
    assign raw[2] = up_data.raw_blue;

    // 255 * ch as (ch << 8) - ch, overflow when the high part reaches clear
    always_comb
    begin
        data_next.divisor = up_data.raw_clear;
        data_next.zero = (up_data.raw_clear == '0);
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            dividend[c] = {raw[c], {QUO_BITS{1'b0}}}
                        - {{QUO_BITS{1'b0}}, raw[c]};
            data_next.rem[c] = dividend[c][DIVIDEND_BITS-1:QUO_BITS];
            data_next.quo[c] = dividend[c][QUO_BITS-1:0];
            data_next.over[c] = !data_next.zero
                && (dividend[c][DIVIDEND_BITS-1:QUO_BITS] >= up_data.raw_clear);
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/cnbc_cell.sv =====
module cnbc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  cnbc_pkg::cell_data_t up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output cnbc_pkg::cell_data_t dn_data,
    input  logic                 dn_ready
);
    import cnbc_pkg::*;

    logic        valid_reg;
    cell_data_t  data_reg;
    cell_data_t  data_next;
    logic [NUM_CHANNELS-1:0][RAW_BITS:0]   shifted;
    logic [NUM_CHANNELS-1:0][RAW_BITS+1:0] diff;
    logic [NUM_CHANNELS-1:0]               take;

    // one restoring step per channel: bring in the next dividend bit,
    // subtract the divisor when it fits, shift the quotient bit in
    always_comb
    begin
        data_next = up_data;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            shifted[c] = {up_data.rem[c], up_data.quo[c][QUO_BITS-1]};
            diff[c] = {1'b0, shifted[c]} - {2'b00, up_data.divisor};
            take[c] = !diff[c][RAW_BITS+1];
            data_next.rem[c] = take[c] ? diff[c][RAW_BITS-1:0]
                                       : shifted[c][RAW_BITS-1:0];
            data_next.quo[c] = {up_data.quo[c][QUO_BITS-2:0], take[c]};
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/cnbc_classify.sv =====
module cnbc_classify (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cnbc_pkg::box_array_t boxes,
    input  logic                 up_valid,
    input  cnbc_pkg::cell_data_t up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output cnbc_pkg::result_t    dn_data,
    input  logic                 dn_ready
);
    import cnbc_pkg::*;

    logic     valid_reg;
    result_t  data_reg;
    result_t  data_next;
    logic [NUM_CHANNELS-1:0][QUO_BITS-1:0] norm;
    logic [NUM_CHANNELS-1:0]               bad;
    logic [NUM_BOXES-1:0]                  hit;
    logic [QUO_BITS-1:0]                   lo;
    logic [QUO_BITS-1:0]                   hi;
    class_t                                cls;

    // final byte per channel: zero clear, saturation, or the quotient
    always_comb
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            bad[c] = up_data.over[c];
            if (up_data.zero)
                norm[c] = '0;
            else if (up_data.over[c])
                norm[c] = NORM_MAX;
            else
                norm[c] = up_data.quo[c];
        end
    end

    // inclusive box tests, first hit in priority order wins
    always_comb
    begin
        lo = '0;
        hi = '0;
        cls = CLS_NONE;
        for (int i = 0; i < NUM_BOXES; i++)
        begin
            hit[i] = 1'b1;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                lo = boxes[i][BOX_BITS-1-QUO_BITS*c -: QUO_BITS];
                hi = boxes[i][BOX_BITS/2-1-QUO_BITS*c -: QUO_BITS];
                if (bad[c] || norm[c] < lo || norm[c] > hi)
                    hit[i] = 1'b0;
            end
        end
        for (int i = NUM_BOXES - 1; i >= 0; i--)
        begin
            if (hit[i])
                cls = BOX_CLASS[i];
        end
    end

    always_comb
    begin
        data_next.color_class = cls;
        data_next.norm_red    = norm[0];
        data_next.norm_green  = norm[1];
        data_next.norm_blue   = norm[2];
        data_next.over_range  = |bad;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cnbc_pkg::*;

    localparam int DRAIN_CYCLES = 14;   // pipeline drain plus margin
    localparam int QUIET_LIMIT  = 4000; // cycles with no transfer at all
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam box_t BOX_ALL    = 48'h0000_00FF_FFFF;
    localparam box_t BOX_ONES   = 48'hFFFF_FFFF_FFFF;
    localparam box_t BOX_ZEROS  = 48'h0000_0000_0000;
    // indexes past the last box, dropped by the block
    localparam logic [INDEX_BITS-1:0] IDX_SPARE_LO = INDEX_BITS'(NUM_BOXES);
    localparam logic [INDEX_BITS-1:0] IDX_SPARE_HI = INDEX_BITS'(NUM_BOXES + 1);

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_index;
    box_t                  cfg_data;

    // shadow of the box registers and the queue of predicted results
    box_t    box_shadow [NUM_BOXES];
    result_t pending_results [$];

    int          error_count;
    int          quiet_cycles;
    bit          tx_random;
    bit          rx_random;
    int unsigned hold_request;
    int unsigned stall_left;

    color_normalize_box_classify dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic box_t mk_box(int lr, int lg, int lb, int hr, int hg, int hb);
        return {8'(lr), 8'(lg), 8'(lb), 8'(hr), 8'(hg), 8'(hb)};
    endfunction

    function automatic sample_t mk_sample(int r, int g, int b, int c);
        sample_t s;
        s.raw_red   = 16'(r);
        s.raw_green = 16'(g);
        s.raw_blue  = 16'(b);
        s.raw_clear = 16'(c);
        return s;
    endfunction

    // normalize the three channels and run the boxes from the lowest priority up
    function automatic result_t classify_sample(sample_t s);
        int unsigned raw [3];
        int unsigned quo;
        logic [7:0]  norm [3];
        bit          over [3];
        bit          fits;
        int unsigned lo;
        int unsigned hi;
        result_t     r;
        raw[0] = s.raw_red;
        raw[1] = s.raw_green;
        raw[2] = s.raw_blue;
        r.over_range = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            over[c] = 1'b0;
            if (s.raw_clear == 0)
                norm[c] = 8'd0;
            else
            begin
                quo = (255 * raw[c]) / s.raw_clear;
                if (quo > 255)
                begin
                    over[c] = 1'b1;
                    norm[c] = NORM_MAX;
                    r.over_range = 1'b1;
                end
                else
                    norm[c] = 8'(quo);
            end
        end
        r.color_class = CLS_NONE;
        for (int i = NUM_BOXES - 1; i >= 0; i--)
        begin
            fits = 1'b1;
            for (int c = 0; c < 3; c++)
            begin
                lo = box_shadow[i][(40 - 8 * c) +: 8];
                hi = box_shadow[i][(16 - 8 * c) +: 8];
                if (over[c] || norm[c] < lo || norm[c] > hi)
                    fits = 1'b0;
            end
            // walking down from the lowest priority, the last hit wins
            if (fits)
                r.color_class = BOX_CLASS[i];
        end
        r.norm_red   = norm[0];
        r.norm_green = norm[1];
        r.norm_blue  = norm[2];
        return r;
    endfunction

    // random sample: mostly channels within clear, plus overflow, zero clear
    // and corner values
    function automatic sample_t random_sample();
        sample_t     s;
        int unsigned mode;
        int unsigned corner [4];
        corner = '{0, 1, 65534, 65535};
        mode = $urandom_range(0, 99);
        if (mode < 65)
        begin
            s.raw_clear = 16'($urandom_range(1, 65535));
            s.raw_red   = 16'($urandom_range(0, s.raw_clear));
            s.raw_green = 16'($urandom_range(0, s.raw_clear));
            s.raw_blue  = 16'($urandom_range(0, s.raw_clear));
        end
        else if (mode < 78)
            s = sample_t'({$urandom, $urandom});
        else if (mode < 88)
        begin
            s.raw_clear = 16'($urandom_range(1, 300));
            s.raw_red   = 16'($urandom_range(0, 320));
            s.raw_green = 16'($urandom_range(0, 320));
            s.raw_blue  = 16'($urandom_range(0, 320));
        end
        else if (mode < 94)
        begin
            s = sample_t'({$urandom, $urandom});
            s.raw_clear = 16'd0;
        end
        else
        begin
            s.raw_red   = 16'(corner[$urandom_range(0, 3)]);
            s.raw_green = 16'(corner[$urandom_range(0, 3)]);
            s.raw_blue  = 16'(corner[$urandom_range(0, 3)]);
            s.raw_clear = 16'(corner[$urandom_range(0, 3)]);
        end
        return s;
    endfunction

    // random box: mostly wide ordinary boxes, plus raw bits, full range,
    // inverted and reset-value boxes
    function automatic box_t random_box();
        int unsigned mode;
        int unsigned lo [3];
        int unsigned hi [3];
        int unsigned flip;
        mode = $urandom_range(0, 99);
        for (int c = 0; c < 3; c++)
        begin
            lo[c] = $urandom_range(0, 170);
            hi[c] = lo[c] + $urandom_range(40, 255 - lo[c]);
        end
        if (mode < 60)
            return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        else if (mode < 75)
            return {16'($urandom), 32'($urandom)};
        else if (mode < 85)
            return BOX_ALL;
        else if (mode < 95)
        begin
            flip = $urandom_range(0, 2);
            lo[flip] = $urandom_range(1, 255);
            hi[flip] = $urandom_range(0, lo[flip] - 1);
            return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        end
        else
            return BOX_RESET;
    endfunction

    // one sample transfer; the prediction is queued when it is accepted
    task automatic send_sample(sample_t s);
        int unsigned gap;
        gap = tx_random ? rand_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid = 1'b1;
        sample       = s;
        do
            @(posedge clk);
        while (sample_stall);
        pending_results.push_back(classify_sample(s));
    endtask

    // one register write; only called with nothing in flight
    task automatic write_box(logic [INDEX_BITS-1:0] idx, box_t data);
        @(negedge clk);
        sample_valid = 1'b0;
        cfg_valid    = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NUM_BOXES)
            box_shadow[idx] = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all_boxes(box_t data);
        for (int i = 0; i < NUM_BOXES; i++)
            write_box(INDEX_BITS'(i), data);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_sample(random_sample());
    endtask

    // reset boxes match nothing, even the all-zero triple
    task automatic test_reset_boxes();
        send_sample(mk_sample(0, 0, 0, 0));
        send_sample(mk_sample(0, 0, 0, 65535));
        send_sample(mk_sample(65535, 65535, 65535, 65535));
        send_sample(mk_sample(1000, 20, 500, 1000));
    endtask

    // one box per class, then samples aimed at each class and corner
    task automatic test_directed_classes();
        wait_drained();
        write_box(REG_BOX_RED,    mk_box(200,   0,   0, 255,  80,  80));
        write_box(REG_BOX_GREEN,  mk_box(  0, 200,   0,  80, 255,  80));
        write_box(REG_BOX_BLUE,   mk_box(  0,   0, 200,  80,  80, 255));
        write_box(REG_BOX_ORANGE, mk_box(200, 100,   0, 255, 180,  60));
        write_box(REG_BOX_BROWN,  mk_box(  0,   0,   0,  60,  60,  60));
        write_box(REG_BOX_YELLOW, mk_box(150, 150,   0, 255, 255, 100));
        send_sample(mk_sample(900, 100, 100, 1000));
        send_sample(mk_sample(100, 900, 100, 1000));
        send_sample(mk_sample(100, 100, 900, 1000));
        send_sample(mk_sample(900, 550, 100, 1000));
        send_sample(mk_sample(100, 100, 100, 1000));
        send_sample(mk_sample(700, 700, 200, 1000));
        send_sample(mk_sample(500, 500, 500, 1000));
        // zero clear still classifies the all-zero triple
        send_sample(mk_sample(1234, 5, 65535, 0));
        send_sample(mk_sample(0, 0, 0, 0));
        // channel above clear saturates and fails every box
        send_sample(mk_sample(2000, 100, 100, 1000));
        send_sample(mk_sample(65535, 65535, 65535, 1));
        // exactly 255 with no overflow, and inclusive bounds
        send_sample(mk_sample(1, 0, 0, 1));
        send_sample(mk_sample(785, 0, 0, 1000));
        send_sample(mk_sample(0, 1000, 0, 1000));
        send_sample(mk_sample(65535, 65535, 65535, 65535));
    endtask

    // inverted box, full box taking the rest, dropped indexes
    task automatic test_box_edits();
        wait_drained();
        write_box(REG_BOX_RED,    mk_box(200, 100, 0, 255, 50, 80));
        write_box(REG_BOX_YELLOW, BOX_ALL);
        write_box(IDX_SPARE_LO,   BOX_ALL);
        write_box(IDX_SPARE_HI,   BOX_ZEROS);
        send_sample(mk_sample(900, 100, 100, 1000));
        send_sample(mk_sample(500, 500, 500, 1000));
        send_sample(mk_sample(3000, 0, 0, 1000));
    endtask

    // all-ones boxes hit only 255,255,255; all-zero boxes only 0,0,0
    task automatic test_box_extremes();
        wait_drained();
        write_all_boxes(BOX_ONES);
        send_sample(mk_sample(65535, 65535, 65535, 65535));
        send_random(20);
        wait_drained();
        write_all_boxes(BOX_ZEROS);
        send_sample(mk_sample(0, 0, 0, 0));
        send_random(20);
    endtask

    // receiver holds off long while the sender keeps offering back to back
    task automatic test_backpressure();
        wait_drained();
        for (int i = 0; i < NUM_BOXES; i++)
            write_box(INDEX_BITS'(i), random_box());
        tx_random = 1'b0;
        rx_random = 1'b0;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        send_random(60);
    endtask

    // random phases with fresh boxes; idling differs per phase
    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            for (int i = 0; i < NUM_BOXES; i++)
                write_box(INDEX_BITS'(i), random_box());
            tx_random = phase[0];
            rx_random = phase[1];
            send_random(120);
            // sender pauses until all results are back
            if (phase == 2)
                wait_drained();
            send_random(120);
        end
    endtask

    // receiver stall: a long hold when asked, else random stalls
    initial
    begin
        result_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                result_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall = 1'b0;
                if (rx_random && $urandom_range(0, 3) == 0)
                    stall_left = rand_gap();
            end
        end
    end

    task automatic report_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    // result check against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h",
                         $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("color_class", want.color_class, result.color_class);
                report_field("norm_red",    want.norm_red,    result.norm_red);
                report_field("norm_green",  want.norm_green,  result.norm_green);
                report_field("norm_blue",   want.norm_blue,   result.norm_blue);
                report_field("over_range",  want.over_range,  result.over_range);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        quiet_cycles = 0;
        tx_random    = 1'b0;
        rx_random    = 1'b0;
        hold_request = 0;
        for (int i = 0; i < NUM_BOXES; i++)
            box_shadow[i] = BOX_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_boxes();
        test_directed_classes();
        test_box_edits();
        test_box_extremes();
        test_backpressure();
        test_random();
        wait_drained();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
